// ===== hw/rtl/picl_pkg.sv =====
// picl_pkg: shared types and constants of the clamped pi controller
// used by picl_ctrl, picl_dp and the pi_controller_clamped top level
package picl_pkg;

    localparam int GAIN_W    = 24;  // unsigned Q8.16 gains
    localparam int DT_W      = 32;  // unsigned Q0.32 time step
    localparam int OUT_FRAC  = 20;  // fractional bits of error, limits and output
    localparam int MUL_W     = 33;  // signed operand width of the shared multiplier
    localparam int PROD_W    = 2 * MUL_W;
    localparam int DT_SHIFT  = 12;
    localparam int KP_SHIFT  = 16;
    localparam int SUM_SHIFT = 4;   // ki*I >> 36 split as >> 32 then >> 4
    localparam int SUM_W     = PROD_W + 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [GAIN_W-1:0] KP_RESET = GAIN_W'(32768);
    localparam logic [GAIN_W-1:0] KI_RESET = GAIN_W'(3276800);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN  = 2'd0,
        REG_INTEG_GAIN = 2'd1,
        REG_LIMIT_LO   = 2'd2,
        REG_LIMIT_HI   = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INTEG,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_FINISH
    } state_t;

    // one-hot step commands from the controller to the datapath
    typedef struct packed {
        logic load;    // capture error, multiply error by time step
        logic integ;   // update integral, multiply error by kp
        logic mul_lo;  // multiply ki by low word of integral
        logic mul_hi;  // multiply ki by high word of integral
        logic finish;  // final sum, clamp, load output register
    } cmd_t;

endpackage

// ===== hw/rtl/picl_ctrl.sv =====
// picl_ctrl: sequencer of the clamped pi controller, input and output handshake
// depends on picl_pkg
module picl_ctrl
    import picl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    output logic out_valid,
    input  logic out_stall,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_stall       = 1'b1;
        // result register empties when the transaction completes
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_INTEG;
                end
            end
            ST_INTEG:
            begin
                cmd.integ  = 1'b1;
                state_next = ST_MUL_LO;
            end
            ST_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // wait while the previous result is still held
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== hw/rtl/picl_dp.sv =====
// picl_dp: datapath of the clamped pi controller: settings, integral,
// shared 33x33 multiplier, final sum and clamp; depends on picl_pkg
module picl_dp
    import picl_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 24,
    parameter int ACC_WIDTH    = 48,
    parameter int CFG_W        = 24
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]           cfg_index,
    input  logic [CFG_W-1:0]               cfg_data,
    input  logic signed [SAMPLE_WIDTH-1:0] error_sample,
    input  logic [DT_W-1:0]                time_step,
    input  cmd_t                           cmd,
    output logic signed [SAMPLE_WIDTH-1:0] control_out
);

    localparam int XW = PROD_W - DT_SHIFT;  // width of e*dt after the shift
    localparam int KW = PROD_W - KP_SHIFT;  // width of kp*e after the shift
    localparam int UW = SUM_W - SUM_SHIFT;
    localparam logic signed [PROD_W-1:0] ACC_MAX =
        (PROD_W'(1) <<< (ACC_WIDTH - 1)) - PROD_W'(1);
    localparam logic signed [PROD_W-1:0] ACC_MIN = -ACC_MAX - PROD_W'(1);

    logic [GAIN_W-1:0]              kp_reg;
    logic [GAIN_W-1:0]              ki_reg;
    logic signed [SAMPLE_WIDTH-1:0] min_reg;
    logic signed [SAMPLE_WIDTH-1:0] max_reg;
    logic signed [ACC_WIDTH-1:0]    acc_reg;
    logic signed [ACC_WIDTH-1:0]    acc_next;
    logic                           started_reg;
    logic signed [SAMPLE_WIDTH-1:0] err_reg;
    logic signed [PROD_W-1:0]       prod_reg;
    logic signed [KW-1:0]           kp_term_reg;
    logic signed [SUM_W-1:0]        pre_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_reg;

    logic signed [MUL_W-1:0]        mul_a;
    logic signed [MUL_W-1:0]        mul_b;
    logic signed [PROD_W-1:0]       prod_full;
    logic signed [PROD_W-1:0]       acc_wide;
    logic signed [XW-1:0]           step_x;
    logic signed [PROD_W-1:0]       step_sat;
    logic signed [PROD_W-1:0]       acc_sum;
    logic signed [SUM_W-1:0]        sum_full;
    logic signed [UW-1:0]           u_val;
    logic signed [UW-1:0]           lo_ext;
    logic signed [UW-1:0]           hi_ext;
    logic signed [SAMPLE_WIDTH-1:0] clamp_val;

    // settings
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg  <= KP_RESET;
            ki_reg  <= KI_RESET;
            min_reg <= '0;
            max_reg <= SAMPLE_WIDTH'(1) <<< OUT_FRAC;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PROP_GAIN:  kp_reg  <= cfg_data[GAIN_W-1:0];
                REG_INTEG_GAIN: ki_reg  <= cfg_data[GAIN_W-1:0];
                REG_LIMIT_LO:   min_reg <= cfg_data[SAMPLE_WIDTH-1:0];
                REG_LIMIT_HI:   max_reg <= cfg_data[SAMPLE_WIDTH-1:0];
                default:        ;
            endcase
        end
    end

    // integral split into a 32-bit low word and a signed high word
    assign acc_wide = PROD_W'(acc_reg);

    always_comb
    begin
        priority if (cmd.load)
        begin
            mul_a = MUL_W'(error_sample);
            mul_b = MUL_W'({1'b0, time_step});
        end
        else if (cmd.integ)
        begin
            mul_a = MUL_W'(err_reg);
            mul_b = MUL_W'({1'b0, kp_reg});
        end
        else if (cmd.mul_lo)
        begin
            mul_a = MUL_W'({1'b0, ki_reg});
            mul_b = MUL_W'({1'b0, acc_reg[31:0]});
        end
        else
        begin
            mul_a = MUL_W'({1'b0, ki_reg});
            mul_b = acc_wide[32+MUL_W-1:32];
        end
    end

    assign prod_full = mul_a * mul_b;

    // saturating integral update from e*dt, floored by the shift
    assign step_x = prod_reg[PROD_W-1:DT_SHIFT];

    always_comb
    begin
        priority if (PROD_W'(step_x) > ACC_MAX)
            step_sat = ACC_MAX;
        else if (PROD_W'(step_x) < ACC_MIN)
            step_sat = ACC_MIN;
        else
            step_sat = PROD_W'(step_x);
        acc_sum = acc_wide + step_sat;
        priority if (acc_sum > ACC_MAX)
            acc_next = ACC_MAX[ACC_WIDTH-1:0];
        else if (acc_sum < ACC_MIN)
            acc_next = ACC_MIN[ACC_WIDTH-1:0];
        else
            acc_next = acc_sum[ACC_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg     <= '0;
            started_reg <= 1'b0;
        end
        else if (cmd.integ)
        begin
            // first step after reset leaves the integral alone
            if (started_reg)
            begin
                acc_reg <= acc_next;
            end
            started_reg <= 1'b1;
        end
    end

    // final sum: (kp_term*16 + (ki*lo >> 32) + ki*hi) >> 4 floors the ki term
    assign sum_full = SUM_W'(prod_reg) + pre_reg;
    assign u_val    = sum_full[SUM_W-1:SUM_SHIFT];
    assign lo_ext   = UW'(min_reg);
    assign hi_ext   = UW'(max_reg);

    always_comb
    begin
        priority if (u_val < lo_ext)
            clamp_val = min_reg;
        else if (u_val > hi_ext)
            clamp_val = max_reg;
        else
            clamp_val = u_val[SAMPLE_WIDTH-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            err_reg <= error_sample;
        end
        if (cmd.load || cmd.integ || cmd.mul_lo || cmd.mul_hi)
        begin
            prod_reg <= prod_full;
        end
        if (cmd.mul_lo)
        begin
            kp_term_reg <= prod_reg[PROD_W-1:KP_SHIFT];
        end
        if (cmd.mul_hi)
        begin
            pre_reg <= (SUM_W'(kp_term_reg) <<< SUM_SHIFT)
                     + SUM_W'({1'b0, prod_reg[GAIN_W+31:32]});
        end
        if (cmd.finish)
        begin
            out_reg <= clamp_val;
        end
    end

    assign control_out = out_reg;

endmodule

// ===== hw/rtl/pi_controller_clamped.sv =====
// pi_controller_clamped: discrete pi controller with clamped output, fixed point
// usage: error_sample and time_step enter on the valid/stall input channel,
// one control_out leaves on the valid/stall output channel for every input
// transaction. error, limits and output are signed with 20 fractional bits,
// time_step is unsigned Q0.32, gains are unsigned Q8.16, the integral is
// signed with 40 fractional bits and saturates at the accumulator range.
// settings are written through cfg_wr_en / cfg_index / cfg_data while idle:
// 0 prop_gain, 1 integ_gain, 2 lower output limit, 3 upper output limit.
// steps per item: input (e*dt), integ (kp*e), low word, high word, finish;
// a new input is taken only in idle. the single shared 33x33 multiplier
// runs four products per item (e*dt, kp*e, ki*low word, ki*high word).
// a finished result sits in the output register, so the next input is
// taken while it waits; a stalled receiver holds the block in its last step
// once the following result is ready, and the input stalls meanwhile.
// reset restores default gains and limits, clears the integral and marks
// the first step as pending, so its time step counts as zero.
// depends on picl_pkg, picl_ctrl, picl_dp
module pi_controller_clamped
    import picl_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 24,
    parameter int ACC_WIDTH    = 48,
    localparam int CFG_W       = (SAMPLE_WIDTH > GAIN_W) ? SAMPLE_WIDTH : GAIN_W
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]           cfg_index,
    input  logic [CFG_W-1:0]               cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] error_sample,
    input  logic [DT_W-1:0]                time_step,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [SAMPLE_WIDTH-1:0] control_out
);

    cmd_t cmd;

    picl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    picl_dp #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .ACC_WIDTH    (ACC_WIDTH),
        .CFG_W        (CFG_W)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .error_sample (error_sample),
        .time_step    (time_step),
        .cmd          (cmd),
        .control_out  (control_out)
    );

endmodule

// ===== hw/rtl/picl_checker.sv =====
// picl_checker: port-level assertions for pi_controller_clamped, with its bind
// depends on the top level's ports only
module picl_checker #(
    parameter int SAMPLE_WIDTH = 24
)
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic signed [SAMPLE_WIDTH-1:0] control_out
);

    logic in_accept;

    assign in_accept = in_valid && !in_stall;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(control_out))
        else $error("stalled result changed or dropped");

    // the input stays stalled while the item of every input transaction is in flight
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> in_stall ##1 in_stall ##1 in_stall ##1 in_stall)
        else $error("input taken while an item is in flight");

    // a new result appears as the block returns to accepting
    a_result_ends_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_stall && $past(in_stall))
        else $error("result appeared without preceding work");

    // after a result is taken with no work pending, nothing new shows up at once
    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !in_stall && !in_valid |=> !out_valid)
        else $error("result invented without an input transaction");

endmodule

bind pi_controller_clamped picl_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_picl_checker (.*);

// ===== sim/pi_controller_clamped_test.sv =====
// pi_controller_clamped_test: self-checking bench for the clamped pi controller
// drives error/time-step transactions, predicts control_out in fixed point, checks in order
// depends on picl_pkg and pi_controller_clamped
`timescale 1ns / 1ps

module pi_controller_clamped_test
    import picl_pkg::*;
();

    localparam int SW             = 24;
    localparam int ACC_W          = 48;
    localparam int CFG_W          = (SW > GAIN_W) ? SW : GAIN_W;
    localparam int KI_SHIFT       = 36;
    localparam int SETTLE_CYCLES  = 8;
    localparam int N_DIRECTED     = 9;
    localparam int N_PHASES       = 10;
    localparam int ITEMS_PER_PHASE = 70;

    localparam logic signed [SW-1:0]   E_MAX   = 24'sh7FFFFF;
    localparam logic signed [SW-1:0]   E_MIN   = 24'sh800000;
    localparam logic signed [SW-1:0]   OUT_ONE = 24'sh100000;
    localparam logic [DT_W-1:0]        DT_MAX  = 32'hFFFF_FFFF;
    localparam logic signed [127:0]    ACC_HI  = (128'sd1 <<< (ACC_W - 1)) - 128'sd1;
    localparam logic signed [127:0]    ACC_LO  = -ACC_HI - 128'sd1;
    localparam logic signed [127:0]    SETTLE_BAND = 128'sd1 <<< 38;

    typedef enum int {
        DRIVE_RANDOM,
        DRIVE_UP,
        DRIVE_DOWN,
        DRIVE_SETTLE
    } drive_mode_t;

    typedef struct {
        logic signed [SW-1:0] err;
        logic [DT_W-1:0]      dt;
        bit                   typed;
        logic signed [SW-1:0] want;
        int unsigned          reps;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic signed [SW-1:0]  error_sample;
    logic [DT_W-1:0]       time_step;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic signed [SW-1:0]  control_out;

    // predictor copy of the settings and state
    logic [GAIN_W-1:0]     kp_q;
    logic [GAIN_W-1:0]     ki_q;
    logic signed [SW-1:0]  out_lo;
    logic signed [SW-1:0]  out_hi;
    logic signed [ACC_W-1:0] integ_acc;
    logic                  started_q;

    logic signed [SW-1:0]  expected_ctrl[$];
    logic signed [SW-1:0]  ctrl_want;

    bit          no_idle = 1'b0;
    int unsigned stall_hold = 0;
    int          fail_count = 0;
    int          results_checked = 0;
    int          items_sent = 0;
    int          settings_done = 0;
    int          hits_lo = 0;
    int          hits_hi = 0;
    int          hits_inside = 0;

    stim_row_t directed_rows [N_DIRECTED] = '{
        // first step after reset: time step counts as zero
        '{E_MAX,        DT_MAX, 1'b1, OUT_ONE,      1},
        '{24'sd0,       32'd0,  1'b1, 24'sd0,       1},
        '{E_MIN,        32'd0,  1'b1, 24'sd0,       1},
        '{24'sh100000,  32'd0,  1'b1, 24'sh080000,  1},
        '{24'sd1,       32'd0,  1'b1, 24'sd0,       1},
        '{-24'sd1,      32'd0,  1'b1, 24'sd0,       1},
        // run the integral into positive saturation
        '{E_MAX,        DT_MAX, 1'b1, OUT_ONE,      17},
        '{E_MIN,        DT_MAX, 1'b0, 24'sd0,       1},
        '{24'sh000123,  32'd1,  1'b0, 24'sd0,       1}
    };

    pi_controller_clamped u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .error_sample (error_sample),
        .time_step    (time_step),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .control_out  (control_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // mostly short, now and then long
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic signed [SW-1:0] next_control(input logic signed [SW-1:0] err,
                                                          input logic [DT_W-1:0] dt);
        logic signed [127:0] err_w;
        logic signed [127:0] dt_w;
        logic signed [127:0] kp_w;
        logic signed [127:0] ki_w;
        logic signed [127:0] lo_w;
        logic signed [127:0] hi_w;
        logic signed [127:0] acc_w;
        logic signed [127:0] ctrl_w;
        err_w = err;
        dt_w  = dt;
        kp_w  = kp_q;
        ki_w  = ki_q;
        lo_w  = out_lo;
        hi_w  = out_hi;
        acc_w = integ_acc;
        if (started_q)
        begin
            acc_w = acc_w + ((err_w * dt_w) >>> DT_SHIFT);
            if (acc_w > ACC_HI)
                acc_w = ACC_HI;
            else if (acc_w < ACC_LO)
                acc_w = ACC_LO;
        end
        started_q = 1'b1;
        integ_acc = acc_w[ACC_W-1:0];
        ctrl_w = ((err_w * kp_w) >>> KP_SHIFT) + ((acc_w * ki_w) >>> KI_SHIFT);
        // lower limit wins when the limits are inverted
        if (ctrl_w < lo_w)
        begin
            hits_lo++;
            return out_lo;
        end
        else if (ctrl_w > hi_w)
        begin
            hits_hi++;
            return out_hi;
        end
        hits_inside++;
        return ctrl_w[SW-1:0];
    endfunction

    task automatic send_sample(input logic signed [SW-1:0] err, input logic [DT_W-1:0] dt,
                               input bit typed, input logic signed [SW-1:0] want);
        logic signed [SW-1:0] predicted;
        int unsigned gap;
        in_valid     <= 1'b1;
        error_sample <= err;
        time_step    <= dt;
        do
            @(posedge clk);
        while (in_stall);
        predicted = next_control(err, dt);
        expected_ctrl.push_back(typed ? want : predicted);
        items_sent++;
        gap = no_idle ? 0 : idle_len();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_ctrl.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_regs(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                              input logic signed [SW-1:0] lo, input logic signed [SW-1:0] hi);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_PROP_GAIN;
        cfg_data  <= CFG_W'(kp);
        @(posedge clk);
        cfg_index <= REG_INTEG_GAIN;
        cfg_data  <= CFG_W'(ki);
        @(posedge clk);
        cfg_index <= REG_LIMIT_LO;
        cfg_data  <= CFG_W'(lo);
        @(posedge clk);
        cfg_index <= REG_LIMIT_HI;
        cfg_data  <= CFG_W'(hi);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        kp_q   = kp;
        ki_q   = ki;
        out_lo = lo;
        out_hi = hi;
        settings_done++;
    endtask

    task automatic choose_sample(input drive_mode_t mode, output logic signed [SW-1:0] err,
                                 output logic [DT_W-1:0] dt);
        logic signed [127:0] acc_w;
        logic signed [127:0] mag;
        int v;
        err = SW'($urandom);
        dt  = $urandom;
        // some noise in every mode
        if ($urandom_range(0, 15) == 0)
            return;
        case (mode)
            DRIVE_RANDOM:
            begin
                if ($urandom_range(0, 7) == 0)
                    err = $urandom_range(0, 1) ? E_MAX : E_MIN;
                if ($urandom_range(0, 7) == 0)
                    dt = $urandom_range(0, 1) ? DT_MAX : 32'd0;
            end
            DRIVE_UP:
            begin
                err = SW'($urandom_range(24'h100000, 24'h7FFFFF));
                dt  = $urandom_range(32'h8000_0000, 32'hFFFF_FFFF);
            end
            DRIVE_DOWN:
            begin
                v   = $urandom_range(24'h100000, 24'h800000);
                err = SW'(-v);
                dt  = $urandom_range(32'h8000_0000, 32'hFFFF_FFFF);
            end
            default:
            begin
                acc_w = integ_acc;
                if (acc_w > SETTLE_BAND || acc_w < -SETTLE_BAND)
                begin
                    // one full-scale step sized to cancel most of the integral
                    mag = ((acc_w < 0) ? -acc_w : acc_w) >>> 11;
                    if (mag > 128'sd4294967295)
                        mag = 128'sd4294967295;
                    dt  = mag[DT_W-1:0];
                    err = (acc_w < 0) ? E_MAX : -E_MAX;
                end
                else
                begin
                    v   = $urandom_range(0, 1 << 17);
                    err = SW'(v - (1 << 16));
                    dt  = $urandom_range(0, 1 << 24);
                end
            end
        endcase
    endtask

    always @(posedge clk)
    begin
        if (stall_hold != 0)
            stall_hold <= stall_hold - 1;
        else
        begin
            out_stall  <= !no_idle && ($urandom_range(0, 2) == 0);
            stall_hold <= idle_len();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_ctrl.size() == 0)
            begin
                $error("control_out: no transaction expected, got %0d", control_out);
                fail_count++;
            end
            else
            begin
                ctrl_want = expected_ctrl.pop_front();
                if (control_out !== ctrl_want)
                begin
                    $error("control_out: expected %0d, got %0d", ctrl_want, control_out);
                    fail_count++;
                end
                results_checked++;
            end
        end
    end

    initial
    begin
        logic signed [SW-1:0] err;
        logic [DT_W-1:0]      dt;
        logic [GAIN_W-1:0]    kp;
        logic [GAIN_W-1:0]    ki;
        logic signed [SW-1:0] lo;
        logic signed [SW-1:0] hi;
        drive_mode_t          mode;
        int                   v;

        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = REG_PROP_GAIN;
        cfg_data     = '0;
        in_valid     = 1'b0;
        error_sample = '0;
        time_step    = '0;
        kp_q         = KP_RESET;
        ki_q         = KI_RESET;
        out_lo       = 24'sd0;
        out_hi       = OUT_ONE;
        integ_acc    = '0;
        started_q    = 1'b0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
            repeat (directed_rows[r].reps)
                send_sample(directed_rows[r].err, directed_rows[r].dt,
                            directed_rows[r].typed, directed_rows[r].want);
        drain();

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            lo = E_MIN;
            hi = E_MAX;
            case (ph)
                0:
                begin
                    kp = '0;
                    ki = '0;
                    mode = DRIVE_RANDOM;
                end
                1:
                begin
                    kp = '1;
                    ki = '1;
                    mode = DRIVE_UP;
                end
                2:
                begin
                    kp = '1;
                    ki = '1;
                    mode = DRIVE_DOWN;
                end
                3:
                begin
                    kp = GAIN_W'($urandom_range(0, 1 << 18));
                    ki = '0;
                    mode = DRIVE_RANDOM;
                end
                4:
                begin
                    kp = KP_RESET;
                    ki = KI_RESET;
                    lo = 24'sd0;
                    hi = OUT_ONE;
                    mode = DRIVE_SETTLE;
                end
                5:
                begin
                    // inverted limits
                    kp = GAIN_W'($urandom);
                    ki = GAIN_W'($urandom);
                    lo = OUT_ONE;
                    hi = -OUT_ONE;
                    mode = DRIVE_RANDOM;
                end
                6:
                begin
                    kp = GAIN_W'($urandom);
                    ki = GAIN_W'($urandom);
                    lo = SW'($urandom);
                    hi = lo;
                    mode = DRIVE_RANDOM;
                end
                default:
                begin
                    kp = $urandom_range(0, 1) ? GAIN_W'($urandom)
                                              : GAIN_W'($urandom_range(0, 1 << 18));
                    ki = $urandom_range(0, 1) ? GAIN_W'($urandom)
                                              : GAIN_W'($urandom_range(0, 1 << 22));
                    v  = $urandom_range(0, 1 << 22);
                    lo = SW'(-v);
                    hi = SW'($urandom_range(0, 1 << 22));
                    mode = (ph == 8) ? DRIVE_RANDOM : DRIVE_SETTLE;
                end
            endcase
            no_idle = (ph == 7);
            write_regs(kp, ki, lo, hi);
            repeat (ITEMS_PER_PHASE)
            begin
                choose_sample(mode, err, dt);
                send_sample(err, dt, 1'b0, 24'sd0);
            end
            drain();
        end

        $display("%0d samples sent, %0d control outputs checked, %0d register settings",
                 items_sent, results_checked, settings_done);
        $display("outputs at lower limit %0d, at upper limit %0d, unclamped %0d",
                 hits_lo, hits_hi, hits_inside);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/picl_pkg.sv
hw/rtl/picl_ctrl.sv
hw/rtl/picl_dp.sv
hw/rtl/pi_controller_clamped.sv
hw/rtl/picl_checker.sv
sim/pi_controller_clamped_test.sv
